// ----- design/bim_pkg.sv -----
// Shared types, codes and helpers for the free-space bitmap allocator.
// Used by every module of the allocator except bim_map_ram; depends on nothing else.
package bim_pkg;

  // Default geometry of the filesystem
  localparam int unsigned NUM_BLOCKS_DEF      = 4096;
  localparam int unsigned RESERVED_BLOCKS_DEF = 13;
  localparam int unsigned NUM_INODES_DEF      = 20;

  // Width of one bitmap word in the block map memory
  localparam int unsigned WORD_BITS = 64;

  // Request operation codes
  localparam logic [2:0] OP_FIND_BLOCK   = 3'd0;
  localparam logic [2:0] OP_ASSIGN_BLOCK = 3'd1;
  localparam logic [2:0] OP_FREE_BLOCK   = 3'd2;
  localparam logic [2:0] OP_FIND_INODE   = 3'd3;
  localparam logic [2:0] OP_ASSIGN_INODE = 3'd4;
  localparam logic [2:0] OP_FREE_INODE   = 3'd5;

  // Response status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_NONE   = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] target_index;
  } bim_req_t;

  typedef struct packed {
    logic [12:0] found_index;
    logic [1:0]  status;
  } bim_rsp_t;

  // Command from the sequencer to the inode map
  typedef struct packed {
    logic        commit;
    logic [2:0]  op;
    logic [11:0] target_index;
  } bim_inode_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RMW,
    S_SCAN,
    S_DONE
  } bim_state_t;

  // Lowest set bit of a 64-bit word: pick the lowest nonzero byte, then the
  // lowest bit inside it. Result is meaningless for an all-zero word.
  function automatic logic [5:0] lowest_set(input logic [63:0] v);
    logic [2:0] grp_sel;
    logic [7:0] grp_val;
    logic [2:0] bit_sel;
    grp_sel = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i*8 +: 8] != 8'h00) grp_sel = 3'(i);
    end
    grp_val = v[{grp_sel, 3'b000} +: 8];
    bit_sel = '0;
    for (int j = 7; j >= 0; j--) begin
      if (grp_val[j]) bit_sel = 3'(j);
    end
    return {grp_sel, bit_sel};
  endfunction

endpackage

// ----- design/bim_map_ram.sv -----
// Block bitmap storage: one write port, one read port, registered read data.
// Depends on nothing; sized by its parameters.
module bim_map_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bim_inode_map.sv -----
// Inode in-use map held in a register, with find, assign and free logic.
// Depends on bim_pkg for codes, the command struct and lowest_set.
module bim_inode_map #(
  parameter int unsigned NUM_INODES = bim_pkg::NUM_INODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bim_pkg::bim_inode_cmd_t cmd,
  output bim_pkg::bim_rsp_t       result
);

  localparam logic [12:0] NONE_INDEX = 13'(NUM_INODES % 8192);
  localparam logic [63:0] INODE_MASK =
    (NUM_INODES >= 64) ? '1 : ((64'(1) << NUM_INODES) - 64'(1));

  logic [NUM_INODES-1:0] inode_map;
  logic [NUM_INODES-1:0] inode_map_next;
  logic [63:0]           free_bits;
  logic [63:0]           bit_mask;
  logic                  target_ok;

  // Only the low NUM_INODES bits can be free
  assign free_bits = ~64'(inode_map) & INODE_MASK;
  assign bit_mask  = 64'(1) << cmd.target_index[5:0];
  assign target_ok = 32'(cmd.target_index) < 32'(NUM_INODES);

  // Decode the request against the current map
  always_comb begin
    inode_map_next = inode_map;
    result.found_index = '0;
    result.status      = bim_pkg::STATUS_REJECT;
    case (cmd.op)
      bim_pkg::OP_FIND_INODE: begin
        if (free_bits != '0) begin
          result.found_index = 13'(bim_pkg::lowest_set(free_bits));
          result.status      = bim_pkg::STATUS_OK;
        end else begin
          result.found_index = NONE_INDEX;
          result.status      = bim_pkg::STATUS_NONE;
        end
      end
      bim_pkg::OP_ASSIGN_INODE: begin
        if (target_ok) begin
          inode_map_next = inode_map | bit_mask[NUM_INODES-1:0];
          result.status  = bim_pkg::STATUS_OK;
        end
      end
      bim_pkg::OP_FREE_INODE: begin
        if (target_ok) begin
          inode_map_next = inode_map & ~bit_mask[NUM_INODES-1:0];
          result.status  = bim_pkg::STATUS_OK;
        end
      end
      default: begin
        inode_map_next = inode_map;
      end
    endcase
  end

  // Update the map only when the sequencer commits the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      inode_map <= '0;
    end else if (cmd.commit) begin
      inode_map <= inode_map_next;
    end
  end

endmodule

// ----- design/bim_block_engine.sv -----
// Request sequencer: clears the block map after reset, scans it for a free
// block, and does read-modify-write for assign and free. Uses bim_pkg,
// bim_map_ram, and the inode map through a command struct.
module bim_block_engine #(
  parameter int unsigned NUM_BLOCKS      = bim_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned RESERVED_BLOCKS = bim_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  bim_pkg::bim_req_t       req,
  output logic                    res_valid,
  input  logic                    res_take,
  output bim_pkg::bim_rsp_t       res,
  output bim_pkg::bim_inode_cmd_t inode_cmd,
  input  bim_pkg::bim_rsp_t       inode_res
);

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + 63) / 64;
  localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned TAIL_BITS = NUM_BLOCKS % 64;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
  localparam logic [63:0] FIRST_MASK = ~((64'(1) << RESERVED_BLOCKS) - 64'(1));
  localparam logic [63:0] TAIL_MASK  =
    (TAIL_BITS == 0) ? '1 : ((64'(1) << TAIL_BITS) - 64'(1));
  localparam logic [12:0] NONE_INDEX = 13'(NUM_BLOCKS % 8192);

  bim_pkg::bim_state_t state;
  bim_pkg::bim_state_t state_next;

  logic [2:0]         op_q;
  logic [11:0]        tgt_q;
  logic [WORD_AW-1:0] chk_idx;
  bim_pkg::bim_rsp_t  res_next;

  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [63:0]        ram_wdata;
  logic [WORD_AW-1:0] ram_raddr;
  logic [63:0]        ram_rdata;

  logic               blk_ok;
  logic [WORD_AW-1:0] tgt_word;
  logic [63:0]        tgt_bit;
  logic [63:0]        free_bits;
  logic               hit;
  logic [31:0]        found_full;

  bim_map_ram #(
    .DEPTH(MAP_WORDS),
    .AW   (WORD_AW),
    .DW   (bim_pkg::WORD_BITS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Target decode for block assign and free
  assign blk_ok   = (32'(tgt_q) >= 32'(RESERVED_BLOCKS)) && (32'(tgt_q) < 32'(NUM_BLOCKS));
  assign tgt_word = WORD_AW'(tgt_q[11:6]);
  assign tgt_bit  = 64'(1) << tgt_q[5:0];

  // Free bits of the word now on the read port, reserved and tail masked off
  always_comb begin
    free_bits = ~ram_rdata;
    if (chk_idx == '0) free_bits = free_bits & FIRST_MASK;
    if (chk_idx == LAST_WORD) free_bits = free_bits & TAIL_MASK;
  end

  assign hit        = free_bits != '0;
  assign found_full = (32'(chk_idx) << 6) | 32'(bim_pkg::lowest_set(free_bits));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bim_pkg::S_CLEAR: begin
        if (chk_idx == LAST_WORD) state_next = bim_pkg::S_IDLE;
      end
      bim_pkg::S_IDLE: begin
        if (req_valid) state_next = bim_pkg::S_EXEC;
      end
      bim_pkg::S_EXEC: begin
        case (op_q) inside
          bim_pkg::OP_FIND_BLOCK: state_next = bim_pkg::S_SCAN;
          bim_pkg::OP_ASSIGN_BLOCK, bim_pkg::OP_FREE_BLOCK:
            state_next = blk_ok ? bim_pkg::S_RMW : bim_pkg::S_DONE;
          default: state_next = bim_pkg::S_DONE;
        endcase
      end
      bim_pkg::S_RMW: begin
        state_next = bim_pkg::S_DONE;
      end
      bim_pkg::S_SCAN: begin
        if (hit || chk_idx == LAST_WORD) state_next = bim_pkg::S_DONE;
      end
      bim_pkg::S_DONE: begin
        if (res_take) state_next = bim_pkg::S_IDLE;
      end
      default: state_next = bim_pkg::S_CLEAR;
    endcase
  end

  // Outputs: memory port, inode command, result to capture
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = '0;
    ram_raddr = chk_idx;
    req_stall = (state != bim_pkg::S_IDLE);
    res_valid = (state == bim_pkg::S_DONE);
    res_next.found_index = '0;
    res_next.status      = bim_pkg::STATUS_REJECT;
    inode_cmd.commit       = 1'b0;
    inode_cmd.op           = op_q;
    inode_cmd.target_index = tgt_q;
    unique case (state)
      bim_pkg::S_CLEAR: begin
        ram_we = 1'b1;
      end
      bim_pkg::S_IDLE: begin
        ram_we = 1'b0;
      end
      bim_pkg::S_EXEC: begin
        case (op_q) inside
          bim_pkg::OP_FIND_BLOCK: ram_raddr = '0;
          bim_pkg::OP_ASSIGN_BLOCK, bim_pkg::OP_FREE_BLOCK: ram_raddr = tgt_word;
          bim_pkg::OP_FIND_INODE, bim_pkg::OP_ASSIGN_INODE, bim_pkg::OP_FREE_INODE: begin
            inode_cmd.commit = 1'b1;
            res_next         = inode_res;
          end
          default: res_next.status = bim_pkg::STATUS_REJECT;
        endcase
      end
      bim_pkg::S_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_word;
        ram_wdata = (op_q == bim_pkg::OP_ASSIGN_BLOCK) ? (ram_rdata | tgt_bit)
                                                       : (ram_rdata & ~tgt_bit);
        res_next.status = bim_pkg::STATUS_OK;
      end
      bim_pkg::S_SCAN: begin
        ram_raddr = chk_idx + 1'b1;
        if (hit) begin
          res_next.found_index = found_full[12:0];
          res_next.status      = bim_pkg::STATUS_OK;
        end else begin
          res_next.found_index = NONE_INDEX;
          res_next.status      = bim_pkg::STATUS_NONE;
        end
      end
      bim_pkg::S_DONE: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // State and word pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bim_pkg::S_CLEAR;
      chk_idx <= '0;
    end else begin
      state <= state_next;
      if (state == bim_pkg::S_CLEAR) begin
        chk_idx <= chk_idx + 1'b1;
      end else if (state == bim_pkg::S_EXEC) begin
        chk_idx <= '0;
      end else if (state == bim_pkg::S_SCAN && state_next == bim_pkg::S_SCAN) begin
        chk_idx <= chk_idx + 1'b1;
      end
    end
  end

  // Hold the request and capture the result on entry to DONE
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      op_q  <= req.op;
      tgt_q <= req.target_index;
    end
    if (state != bim_pkg::S_DONE && state_next == bim_pkg::S_DONE) begin
      res <= res_next;
    end
  end

  // An accepted transaction goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == bim_pkg::S_EXEC)
    else $error("accepted transaction did not enter execution");

  // Write-back hits the word that was read the cycle before
  a_rmw_same_word: assert property (@(posedge clk) disable iff (rst)
    state == bim_pkg::S_RMW |-> ram_waddr == $past(ram_raddr))
    else $error("write-back address differs from read address");

  // The map is never written while it is being scanned
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == bim_pkg::S_SCAN |-> !ram_we)
    else $error("bitmap written during scan");

  // A none-free result carries the map size as its index
  a_none_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == bim_pkg::STATUS_NONE) |->
      (res.found_index == NONE_INDEX ||
       res.found_index == inode_res.found_index))
    else $error("none-free result with wrong index");

endmodule

// ----- design/block_inode_bitmap_allocator_top.sv -----
// Top level of the free-space bitmap allocator: sequencer, inode map and
// response register. Depends on bim_pkg, bim_block_engine, bim_inode_map.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   bim_req_t (op, target_index)
//   rsp      out        rsp_valid/rsp_stall   bim_rsp_t (found_index, status)
//
// After reset the block map memory is cleared one word a cycle, with
// req_stall held high. One transaction at a time; the next is taken only
// after the previous result moves into the response register. Find block
// examines one word per cycle, set by the memory read port, and stops at
// the first word with a free block or at the last word. Assign or free
// block: read, then write back. Inode ops and rejected requests go straight
// from execution to done. A stalled response holds; the sequencer keeps its
// finished result and takes no new request until that result is passed on.
module block_inode_bitmap_allocator_top #(
  parameter int unsigned NUM_BLOCKS      = bim_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned RESERVED_BLOCKS = bim_pkg::RESERVED_BLOCKS_DEF,
  parameter int unsigned NUM_INODES      = bim_pkg::NUM_INODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  bim_pkg::bim_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bim_pkg::bim_rsp_t rsp
);

  logic                    res_valid;
  logic                    res_take;
  bim_pkg::bim_rsp_t       res;
  bim_pkg::bim_inode_cmd_t inode_cmd;
  bim_pkg::bim_rsp_t       inode_res;

  bim_block_engine #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .RESERVED_BLOCKS(RESERVED_BLOCKS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .inode_cmd(inode_cmd),
    .inode_res(inode_res)
  );

  bim_inode_map #(
    .NUM_INODES(NUM_INODES)
  ) u_inode_map (
    .clk   (clk),
    .rst   (rst),
    .cmd   (inode_cmd),
    .result(inode_res)
  );

  // Response register takes a result whenever it is empty or draining
  assign res_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) rsp <= res;
  end

endmodule
